>>> hw/rtl/rcm_pkg.sv
// rcm_pkg: widths, reset values, register indexes, opcodes, sequencer states and
// handshake structs for the RSA CRT modular exponentiation block. No dependencies.
package rcm_pkg;

	localparam int MOD_WIDTH = 32;
	localparam int EXP_WIDTH = 64;
	localparam int MSG_WIDTH = 64;
	localparam int RES_WIDTH = 64;
	localparam int X_WIDTH   = (MSG_WIDTH > EXP_WIDTH) ? MSG_WIDTH : EXP_WIDTH;
	localparam int ACC_WIDTH = 2 * MOD_WIDTH;
	localparam int SUM_WIDTH = 2 * MOD_WIDTH + 1;
	localparam int CNT_WIDTH = $clog2(X_WIDTH + 1);
	localparam int SH_MOD    = X_WIDTH - MOD_WIDTH;
	localparam int SH_EXP    = X_WIDTH - EXP_WIDTH;
	localparam int SH_MSG    = X_WIDTH - MSG_WIDTH;

	localparam logic [MOD_WIDTH-1:0] PRIME_P_RST = MOD_WIDTH'(97579);
	localparam logic [MOD_WIDTH-1:0] PRIME_Q_RST = MOD_WIDTH'(97583);

	// register indexes (paddr[2])
	localparam logic REG_PRIME_P = 1'b0;
	localparam logic REG_PRIME_Q = 1'b1;

	typedef enum logic [1:0] {
		ALU_DIV,
		ALU_MODMUL,
		ALU_MUL
	} alu_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_ERED,
		S_MRED,
		S_PTEST,
		S_PMUL,
		S_PSQR,
		S_ITEST,
		S_IDIV,
		S_IMUL,
		S_IUPD,
		S_CMBU,
		S_CMBT,
		S_NMUL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                 start;
		alu_op_t              op;
		logic [CNT_WIDTH-1:0] nbits;
		logic [X_WIDTH-1:0]   x;
		logic [MOD_WIDTH-1:0] a;
		logic [MOD_WIDTH-1:0] m;
	} alu_req_t;

	typedef struct packed {
		logic                 done;
		logic [ACC_WIDTH-1:0] acc;
		logic [X_WIDTH-1:0]   quo;
	} alu_rsp_t;

endpackage

>>> hw/rtl/rcm_alu.sv
// rcm_alu: bit-serial arithmetic unit, one operand bit per cycle, MSB first:
// restoring divide/remainder, modular multiply, plain multiply. Uses rcm_pkg.
module rcm_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  rcm_pkg::alu_req_t  req,
	output rcm_pkg::alu_rsp_t  rsp
);

	rcm_pkg::alu_op_t                  op_q;
	logic [rcm_pkg::X_WIDTH-1:0]       x_q;
	logic [rcm_pkg::MOD_WIDTH-1:0]     a_q;
	logic [rcm_pkg::MOD_WIDTH-1:0]     m_q;
	logic [rcm_pkg::ACC_WIDTH-1:0]     acc_q;
	logic [rcm_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic                              xb;
	logic [rcm_pkg::MOD_WIDTH:0]       div_r;
	logic                              div_ge;
	logic [rcm_pkg::MOD_WIDTH:0]       div_nx;
	logic [rcm_pkg::MOD_WIDTH+1:0]     mm_t;
	logic [rcm_pkg::MOD_WIDTH+1:0]     mm_m1;
	logic [rcm_pkg::MOD_WIDTH+1:0]     mm_m2;
	logic [rcm_pkg::MOD_WIDTH+1:0]     mm_nx;
	logic [rcm_pkg::ACC_WIDTH-1:0]     mul_nx;

	always_comb begin
		xb     = x_q[rcm_pkg::X_WIDTH-1];
		div_r  = {acc_q[rcm_pkg::MOD_WIDTH-1:0], xb};
		div_ge = div_r >= {1'b0, m_q};
		div_nx = div_ge ? (div_r - {1'b0, m_q}) : div_r;
		// acc < m, so 2*acc + a < 3m: at most two subtractions of m
		mm_t   = {1'b0, acc_q[rcm_pkg::MOD_WIDTH-1:0], 1'b0}
			+ (xb ? {2'b00, a_q} : '0);
		mm_m1  = {2'b00, m_q};
		mm_m2  = {1'b0, m_q, 1'b0};
		if (mm_t >= mm_m2) begin
			mm_nx = mm_t - mm_m2;
		end else if (mm_t >= mm_m1) begin
			mm_nx = mm_t - mm_m1;
		end else begin
			mm_nx = mm_t;
		end
		mul_nx = {acc_q[rcm_pkg::ACC_WIDTH-2:0], 1'b0}
			+ (xb ? rcm_pkg::ACC_WIDTH'(a_q) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcm_pkg::CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			x_q   <= req.x;
			a_q   <= req.a;
			m_q   <= req.m;
			acc_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				rcm_pkg::ALU_DIV: begin
					acc_q <= rcm_pkg::ACC_WIDTH'(div_nx);
					x_q   <= {x_q[rcm_pkg::X_WIDTH-2:0], div_ge};
				end
				rcm_pkg::ALU_MODMUL: begin
					acc_q <= rcm_pkg::ACC_WIDTH'(mm_nx);
					x_q   <= {x_q[rcm_pkg::X_WIDTH-2:0], 1'b0};
				end
				rcm_pkg::ALU_MUL: begin
					acc_q <= mul_nx;
					x_q   <= {x_q[rcm_pkg::X_WIDTH-2:0], 1'b0};
				end
				default: begin
					acc_q <= acc_q;
					x_q   <= x_q;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;
	assign rsp.quo  = x_q;

endmodule

>>> hw/rtl/rsa_crt_modexp.sv
// rsa_crt_modexp: top level, sequencer, configuration registers and CRT
// datapath around one bit-serial unit. Uses rcm_pkg and rcm_alu.
//
//  channel   direction  handshake          payload
//  config    in/out     psel/penable/pready paddr, pwdata, prdata
//  input     in         in_valid/in_ready  message, exponent
//  result    out        out_valid/out_ready result_value
//
// Every multiply, division and reduction runs on rcm_alu, one bit per cycle;
// the Euclid update and the final CRT sum and subtraction are done locally.
// When a prime is 0 or 1, an item goes straight to the modulus product.
// One item is in work at a time; in_ready is high only when idle, and a
// finished result waits in the output register while the next item is taken.
// Reset loads the primes with their defaults and clears out_valid.
module rsa_crt_modexp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rcm_pkg::MSG_WIDTH-1:0]   message,
	input  logic [63:0]                     exponent,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rcm_pkg::RES_WIDTH-1:0]   result_value
);

	localparam int MW = rcm_pkg::MOD_WIDTH;

	rcm_pkg::state_t               state_q, state_nx;
	logic                          run_q;
	logic                          h_q;
	logic                          out_valid_q;
	logic [MW-1:0]                 prime_p_q;
	logic [MW-1:0]                 prime_q_q;
	logic [rcm_pkg::MSG_WIDTH-1:0] msg_q;
	logic [rcm_pkg::EXP_WIDTH-1:0] exp_q;
	logic [MW-1:0]                 er_q;
	logic [MW-1:0]                 base_q;
	logic [MW-1:0]                 pacc_q;
	logic [MW-1:0]                 ra_q;
	logic [MW-1:0]                 rb_q;
	logic [MW-1:0]                 cx_q;
	logic [MW-1:0]                 cy_q;
	logic [rcm_pkg::SUM_WIDTH-1:0] sum_q;
	logic [rcm_pkg::RES_WIDTH-1:0] res_q;

	rcm_pkg::alu_req_t             alu_req;
	rcm_pkg::alu_rsp_t             alu_rsp;

	logic [MW-1:0]                 m_cur;
	logic [MW-1:0]                 o_cur;
	logic                          unit_st;
	logic                          degen;
	logic                          out_free;
	logic [rcm_pkg::SUM_WIDTH-1:0] n_ext;
	logic [MW:0]                   cy_sub;
	logic                          cfg_wr;

	rcm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign m_cur    = h_q ? prime_q_q : prime_p_q;
	assign o_cur    = h_q ? prime_p_q : prime_q_q;
	assign degen    = (prime_p_q < MW'(2)) || (prime_q_q < MW'(2));
	assign out_free = !out_valid_q || out_ready;
	assign n_ext    = {1'b0, msg_q[rcm_pkg::ACC_WIDTH-1:0]};
	// cx - qt*cy mod m; base_q holds qt*cy mod m
	assign cy_sub   = (cx_q >= base_q) ? ({1'b0, cx_q} - {1'b0, base_q})
		: ({1'b0, cx_q} + {1'b0, m_cur} - {1'b0, base_q});
	assign cfg_wr   = psel && penable && pwrite;

	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == rcm_pkg::REG_PRIME_Q) ? 32'(prime_q_q) : 32'(prime_p_q);
	assign out_valid    = out_valid_q;
	assign result_value = res_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rcm_pkg::S_IDLE: if (in_valid) state_nx = rcm_pkg::S_CHK;
			rcm_pkg::S_CHK:  state_nx = degen ? rcm_pkg::S_NMUL : rcm_pkg::S_ERED;
			rcm_pkg::S_ERED: if (alu_rsp.done) state_nx = rcm_pkg::S_MRED;
			rcm_pkg::S_MRED: if (alu_rsp.done) state_nx = rcm_pkg::S_PTEST;
			rcm_pkg::S_PTEST: begin
				if (er_q == '0) begin
					state_nx = rcm_pkg::S_ITEST;
				end else if (er_q[0]) begin
					state_nx = rcm_pkg::S_PMUL;
				end else begin
					state_nx = rcm_pkg::S_PSQR;
				end
			end
			rcm_pkg::S_PMUL: if (alu_rsp.done) state_nx = rcm_pkg::S_PSQR;
			rcm_pkg::S_PSQR: if (alu_rsp.done) state_nx = rcm_pkg::S_PTEST;
			rcm_pkg::S_ITEST: begin
				if (ra_q <= MW'(1) || rb_q == '0) begin
					state_nx = rcm_pkg::S_CMBU;
				end else begin
					state_nx = rcm_pkg::S_IDIV;
				end
			end
			rcm_pkg::S_IDIV: if (alu_rsp.done) state_nx = rcm_pkg::S_IMUL;
			rcm_pkg::S_IMUL: if (alu_rsp.done) state_nx = rcm_pkg::S_IUPD;
			rcm_pkg::S_IUPD: state_nx = rcm_pkg::S_ITEST;
			rcm_pkg::S_CMBU: if (alu_rsp.done) state_nx = rcm_pkg::S_CMBT;
			rcm_pkg::S_CMBT: begin
				if (alu_rsp.done) state_nx = h_q ? rcm_pkg::S_NMUL : rcm_pkg::S_ERED;
			end
			rcm_pkg::S_NMUL: if (alu_rsp.done) state_nx = rcm_pkg::S_FIN;
			rcm_pkg::S_FIN:  if (out_free) state_nx = rcm_pkg::S_IDLE;
			default:         state_nx = rcm_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake and unit request
	always_comb begin
		in_ready      = 1'b0;
		unit_st       = 1'b0;
		alu_req.op    = rcm_pkg::ALU_DIV;
		alu_req.nbits = rcm_pkg::CNT_WIDTH'(MW);
		alu_req.x     = rcm_pkg::X_WIDTH'(base_q) << rcm_pkg::SH_MOD;
		alu_req.a     = base_q;
		alu_req.m     = m_cur;
		unique case (state_q)
			rcm_pkg::S_IDLE: in_ready = 1'b1;
			rcm_pkg::S_ERED: begin
				unit_st       = 1'b1;
				alu_req.nbits = rcm_pkg::CNT_WIDTH'(rcm_pkg::EXP_WIDTH);
				alu_req.x     = rcm_pkg::X_WIDTH'(exp_q) << rcm_pkg::SH_EXP;
				alu_req.m     = m_cur - MW'(1);
			end
			rcm_pkg::S_MRED: begin
				unit_st       = 1'b1;
				alu_req.nbits = rcm_pkg::CNT_WIDTH'(rcm_pkg::MSG_WIDTH);
				alu_req.x     = rcm_pkg::X_WIDTH'(msg_q) << rcm_pkg::SH_MSG;
			end
			rcm_pkg::S_PMUL: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MODMUL;
				alu_req.x  = rcm_pkg::X_WIDTH'(pacc_q) << rcm_pkg::SH_MOD;
			end
			rcm_pkg::S_PSQR: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MODMUL;
			end
			rcm_pkg::S_IDIV: begin
				unit_st   = 1'b1;
				alu_req.x = rcm_pkg::X_WIDTH'(ra_q) << rcm_pkg::SH_MOD;
				alu_req.m = rb_q;
			end
			rcm_pkg::S_IMUL: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MODMUL;
				alu_req.x  = rcm_pkg::X_WIDTH'(er_q) << rcm_pkg::SH_MOD;
				alu_req.a  = cy_q;
			end
			rcm_pkg::S_CMBU: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MODMUL;
				alu_req.x  = rcm_pkg::X_WIDTH'(pacc_q) << rcm_pkg::SH_MOD;
				alu_req.a  = cx_q;
			end
			rcm_pkg::S_CMBT: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MUL;
				alu_req.a  = o_cur;
			end
			rcm_pkg::S_NMUL: begin
				unit_st    = 1'b1;
				alu_req.op = rcm_pkg::ALU_MUL;
				alu_req.x  = rcm_pkg::X_WIDTH'(prime_p_q) << rcm_pkg::SH_MOD;
				alu_req.a  = prime_q_q;
			end
			default: in_ready = 1'b0;
		endcase
		alu_req.start = unit_st && !run_q;
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcm_pkg::S_IDLE;
			run_q       <= 1'b0;
			h_q         <= 1'b0;
			out_valid_q <= 1'b0;
			prime_p_q   <= rcm_pkg::PRIME_P_RST;
			prime_q_q   <= rcm_pkg::PRIME_Q_RST;
		end else begin
			state_q <= state_nx;
			if (alu_req.start) begin
				run_q <= 1'b1;
			end else if (alu_rsp.done) begin
				run_q <= 1'b0;
			end
			if (state_q == rcm_pkg::S_CHK) begin
				h_q <= 1'b0;
			end else if (state_q == rcm_pkg::S_CMBT && alu_rsp.done) begin
				h_q <= 1'b1;
			end
			if (state_q == rcm_pkg::S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[2] == rcm_pkg::REG_PRIME_P) begin
				prime_p_q <= pwdata[MW-1:0];
			end
			if (cfg_wr && paddr[2] == rcm_pkg::REG_PRIME_Q) begin
				prime_q_q <= pwdata[MW-1:0];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rcm_pkg::S_IDLE: begin
				if (in_valid) begin
					msg_q <= message;
					exp_q <= exponent[rcm_pkg::EXP_WIDTH-1:0];
				end
			end
			rcm_pkg::S_CHK: sum_q <= '0;
			rcm_pkg::S_ERED: if (alu_rsp.done) er_q <= alu_rsp.acc[MW-1:0];
			rcm_pkg::S_MRED: begin
				if (alu_rsp.done) begin
					base_q <= alu_rsp.acc[MW-1:0];
					pacc_q <= MW'(1);
				end
			end
			rcm_pkg::S_PTEST: begin
				if (er_q == '0) begin
					ra_q <= o_cur;
					rb_q <= m_cur;
					cx_q <= MW'(1);
					cy_q <= '0;
				end
			end
			rcm_pkg::S_PMUL: if (alu_rsp.done) pacc_q <= alu_rsp.acc[MW-1:0];
			rcm_pkg::S_PSQR: begin
				if (alu_rsp.done) begin
					base_q <= alu_rsp.acc[MW-1:0];
					er_q   <= er_q >> 1;
				end
			end
			rcm_pkg::S_ITEST: begin
				// no inverse: gcd above one
				if (ra_q != MW'(1) && (ra_q == '0 || rb_q == '0)) cx_q <= '0;
			end
			rcm_pkg::S_IDIV: begin
				if (alu_rsp.done) begin
					er_q <= alu_rsp.quo[MW-1:0];
					ra_q <= rb_q;
					rb_q <= alu_rsp.acc[MW-1:0];
				end
			end
			rcm_pkg::S_IMUL: if (alu_rsp.done) base_q <= alu_rsp.acc[MW-1:0];
			rcm_pkg::S_IUPD: begin
				cy_q <= cy_sub[MW-1:0];
				cx_q <= cy_q;
			end
			rcm_pkg::S_CMBU: if (alu_rsp.done) base_q <= alu_rsp.acc[MW-1:0];
			rcm_pkg::S_CMBT: begin
				if (alu_rsp.done) sum_q <= sum_q + {1'b0, alu_rsp.acc};
			end
			rcm_pkg::S_NMUL: begin
				if (alu_rsp.done) msg_q <= rcm_pkg::MSG_WIDTH'(alu_rsp.acc);
			end
			rcm_pkg::S_FIN: begin
				if (out_free) begin
					res_q <= (sum_q >= n_ext) ? rcm_pkg::RES_WIDTH'(sum_q - n_ext)
						: rcm_pkg::RES_WIDTH'(sum_q);
				end
			end
			default: sum_q <= sum_q;
		endcase
	end

	a_done_launched: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> run_q)
		else $error("unit finished without a launch");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rcm_pkg::S_IDLE |-> !run_q)
		else $error("unit busy while idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == rcm_pkg::S_CHK)
		else $error("accepted item did not start");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rcm_pkg::S_FIN && out_free |=> out_valid_q)
		else $error("result not presented");

endmodule

>>> dv/tb_rsa_crt_modexp.sv
// tb_rsa_crt_modexp: self-checking testbench for the RSA CRT modular exponentiation block.
// A directed table runs first, then random items under several prime settings.
// Depends on rcm_pkg and rsa_crt_modexp.
module tb_rsa_crt_modexp;

	localparam longint      LIMIT      = 64'd8_000_000;
	localparam int          HOLD_TICKS = 30000;
	localparam int          N_PHASES   = 8;
	localparam int          PER_PHASE  = 12;
	localparam logic [31:0] RST_P      = 32'(rcm_pkg::PRIME_P_RST);
	localparam logic [31:0] RST_Q      = 32'(rcm_pkg::PRIME_Q_RST);

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]                    paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [rcm_pkg::MSG_WIDTH-1:0] message = '0;
	logic [63:0]                   exponent = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [rcm_pkg::RES_WIDTH-1:0] result_value;

	rsa_crt_modexp dut (.*);

	typedef struct {
		logic [31:0] p;
		logic [31:0] q;
		logic [63:0] msg;
		logic [63:0] ex;
		bit          known;
		logic [63:0] val;
	} row_t;

	logic [63:0] pending_results[$];
	logic [31:0] cur_p = RST_P, cur_q = RST_Q;
	int          errors = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	longint      cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				acc = (acc * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	// extended Euclid; 0 when a has no inverse modulo m
	function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
		longint      cx, cy, ty, m0;
		logic [63:0] ra, rb, qt, t;
		m0 = longint'(m);
		cx = 1;
		cy = 0;
		ra = a;
		rb = m;
		if (m == 1 || ra == 0)
			return 64'd0;
		while (ra > 1) begin
			if (rb == 0)
				return 64'd0;
			qt = ra / rb;
			t = rb;
			rb = ra % rb;
			ra = t;
			ty = cy;
			cy = cx - longint'(qt) * cy;
			cx = ty;
		end
		cx = cx % m0;
		if (cx < 0)
			cx = cx + m0;
		return 64'(cx);
	endfunction

	function automatic logic [63:0] crt_power(logic [63:0] msg, logic [63:0] ex);
		logic [63:0] p, q, mp, mq, qinv, pinv, n, t1, t2;
		logic [64:0] s;
		p = 64'(cur_p);
		q = 64'(cur_q);
		if (p < 2 || q < 2)
			return 64'd0;
		mp = pow_mod(msg, ex % (p - 1), p);
		mq = pow_mod(msg, ex % (q - 1), q);
		qinv = inverse_mod(q, p);
		pinv = inverse_mod(p, q);
		n = p * q;
		t1 = ((mp * qinv) % p) * q;
		t2 = ((mq * pinv) % q) * p;
		s = {1'b0, t1} + {1'b0, t2};
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[63:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result_value);
				errors++;
			end else begin
				if (result_value !== pending_results[0]) begin
					$display("%0t: result_value mismatch, expected %h, actual %h",
						$time, pending_results[0], result_value);
					errors++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// result side: random stalls, one long hold-off when asked
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_TICKS) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// setup and access phases, then the bus returns to idle
	task automatic apb_write(logic sel, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// drain, then write the primes while idle
	task automatic load_primes(logic [31:0] p, logic [31:0] q);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		apb_write(rcm_pkg::REG_PRIME_P, p);
		apb_write(rcm_pkg::REG_PRIME_Q, q);
		cur_p = p;
		cur_q = q;
	endtask

	// leaves in_valid high after acceptance unless a gap follows
	task automatic send_item(logic [63:0] msg, logic [63:0] ex, bit known, logic [63:0] val);
		in_valid <= 1'b1;
		message <= msg;
		exponent <= ex;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(known ? val : crt_power(msg, ex));
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_prime();
		logic [31:0] pool[10] = '{32'd3, 32'd5, 32'd7, 32'd65537, 32'd97579, 32'd97583,
			32'd1000003, 32'd2147483647, 32'd4294967279, 32'd4294967291};
		return pool[$urandom_range(0, 9)];
	endfunction

	row_t table_rows[] = '{
		'{RST_P, RST_Q, 64'd5, 64'd0, 1, 64'd1},
		'{RST_P, RST_Q, 64'd0, 64'd1, 1, 64'd0},
		'{RST_P, RST_Q, 64'd97579, 64'd0, 1, 64'd1},
		'{RST_P, RST_Q, 64'd1234567, 64'd65537, 0, 64'd0},
		'{RST_P, RST_Q, '1, '1, 0, 64'd0},
		'{RST_P, RST_Q, 64'd42, 64'd97578 * 64'd97582, 1, 64'd1},
		'{RST_P, RST_Q, 64'h8000_0000_0000_0000, 64'd97578, 0, 64'd0},
		'{32'd0, 32'd97583, 64'd77, 64'd3, 1, 64'd0},
		'{32'd1, 32'd97583, '1, '1, 1, 64'd0},
		'{32'd97579, 32'd0, 64'd9, 64'd9, 1, 64'd0},
		'{32'd97579, 32'd1, 64'd9, 64'd9, 1, 64'd0},
		'{32'd97579, 32'd97579, 64'd123, 64'd17, 0, 64'd0},
		'{32'd15, 32'd21, 64'd11, 64'd5, 0, 64'd0},
		'{32'd3, 32'd5, 64'd14, 64'd3, 0, 64'd0},
		'{32'd2, 32'd3, 64'd5, 64'd7, 0, 64'd0},
		'{32'd4294967291, 32'd4294967279, '1, '1, 0, 64'd0},
		'{32'd4294967291, 32'd4294967279, 64'hFFFF_FFFE_0000_0001, 64'd1, 0, 64'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 64'hDEAD_BEEF_0123_4567, 64'd65537, 0, 64'd0},
		'{32'd97579, 32'd97583, 64'd0, 64'd0, 1, 64'd1}
	};

	initial begin
		logic [31:0] np, nq;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].p != cur_p || table_rows[i].q != cur_q)
				load_primes(table_rows[i].p, table_rows[i].q);
			send_item(table_rows[i].msg, table_rows[i].ex, table_rows[i].known,
				table_rows[i].val);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			np = pick_prime();
			nq = pick_prime();
			if (ph == 2)
				np = $urandom();
			if (nq == np && $urandom_range(0, 1))
				nq = 32'd97583;
			load_primes(np, nq);
			calm = (ph == N_PHASES - 1);
			for (int k = 0; k < PER_PHASE; k++) begin
				if (ph == 3 && k == 2)
					hold_req = 1'b1;
				case ($urandom_range(0, 3))
					0: send_item({$urandom(), $urandom()}, {$urandom(), $urandom()}, 0, 0);
					1: send_item({$urandom(), $urandom()}, 64'($urandom_range(0, 70000)), 0, 0);
					2: send_item(64'($urandom()), {32'd0, $urandom()}, 0, 0);
					default: send_item({$urandom(), $urandom()},
						64'(cur_p - 1) * $urandom_range(0, 3), 0, 0);
				endcase
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/rcm_pkg.sv
hw/rtl/rcm_alu.sv
hw/rtl/rsa_crt_modexp.sv
dv/tb_rsa_crt_modexp.sv
